/* rtl/isa_pkg.sv */
// ----------------------------------------------------------------------------
// Image similarity accumulator package
// Widths, derived sizes and the command and status types shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package isa_pkg;

    // Largest image is 2**MAX_PIXELS_LOG2 pixel pairs.
    localparam int MAX_PIXELS_LOG2 = 22;
    // Fraction bits of the similarity results and of each per-pixel ratio.
    localparam int FRACTION_BITS   = 16;

    localparam int PIX_W     = 8;
    localparam int PROD_W    = 2 * PIX_W;
    localparam int SQ_W      = PROD_W + MAX_PIXELS_LOG2;
    localparam int RATIO_W   = FRACTION_BITS + MAX_PIXELS_LOG2 + 1;
    localparam int CNT_W     = MAX_PIXELS_LOG2 + 1;
    localparam int SIM_W     = FRACTION_BITS + 1;
    localparam int DEN_W     = SQ_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int DIV_STEPS = FRACTION_BITS + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // capture a pixel pair and accumulate its products
        logic ratio_add;  // add the finished per-pixel ratio
        logic den_load;   // form the Tanimoto denominator
        logic tan_start;  // start the Tanimoto division
        logic tan_save;   // keep the Tanimoto quotient
        logic mr_start;   // start the mean-ratio division
        logic finish;     // load the result register and clear the sums
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;   // the shared divider is iterating
        logic out_free;   // the result register can take a new result
    } t_dp_stat;

endpackage

/* rtl/isa_pix_if.sv */
// ----------------------------------------------------------------------------
// Pixel pair channel
// Carries one pixel pair of the two images and the last-pixel marker.
// ----------------------------------------------------------------------------
interface isa_pix_if;
    logic                      valid;
    logic                      ready;
    logic [isa_pkg::PIX_W-1:0] pixel_first;
    logic [isa_pkg::PIX_W-1:0] pixel_second;
    logic                      last_pixel;

    modport source (output valid, output pixel_first, output pixel_second,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_first, input pixel_second,
                    input last_pixel, output ready);
endinterface

/* rtl/isa_res_if.sv */
// ----------------------------------------------------------------------------
// Similarity result channel
// Carries the similarity figures, the raw sums and the two flags of an image.
// ----------------------------------------------------------------------------
interface isa_res_if;
    logic                        valid;
    logic                        ready;
    logic [isa_pkg::SIM_W-1:0]   tanimoto_similarity;
    logic [isa_pkg::SIM_W-1:0]   min_ratio_similarity;
    logic [isa_pkg::SQ_W-1:0]    inner_product;
    logic [isa_pkg::SQ_W-1:0]    sum_squares_first;
    logic [isa_pkg::SQ_W-1:0]    sum_squares_second;
    logic [isa_pkg::RATIO_W-1:0] ratio_total;
    logic [isa_pkg::CNT_W-1:0]   pixel_total;
    logic                        tanimoto_undefined;
    logic                        too_many_pixels;

    modport source (output valid, output tanimoto_similarity,
                    output min_ratio_similarity, output inner_product,
                    output sum_squares_first, output sum_squares_second,
                    output ratio_total, output pixel_total,
                    output tanimoto_undefined, output too_many_pixels,
                    input ready);
    modport sink   (input valid, input tanimoto_similarity,
                    input min_ratio_similarity, input inner_product,
                    input sum_squares_first, input sum_squares_second,
                    input ratio_total, input pixel_total,
                    input tanimoto_undefined, input too_many_pixels,
                    output ready);
endinterface

/* rtl/isa_div.sv */
// ----------------------------------------------------------------------------
// Shared fractional divider
// Restoring divider, one quotient bit per cycle, FRACTION_BITS+1 bits.
// ----------------------------------------------------------------------------
module isa_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [isa_pkg::REM_W-1:0]          i_num,
    input  logic [isa_pkg::DEN_W-1:0]          i_den,
    input  logic [isa_pkg::FRACTION_BITS-1:0]  i_low,
    output logic                               o_busy,
    output logic [isa_pkg::SIM_W-1:0]          o_quot
);

    logic                              r_busy;
    logic [isa_pkg::STEP_W-1:0]        r_step;
    logic [isa_pkg::REM_W-1:0]         r_rem;
    logic [isa_pkg::DEN_W-1:0]         r_den;
    logic [isa_pkg::FRACTION_BITS-1:0] r_low;
    logic [isa_pkg::SIM_W-1:0]         r_quot;
    logic [isa_pkg::REM_W-1:0]         w_trial;
    logic [isa_pkg::REM_W-1:0]         w_diff;
    logic [isa_pkg::REM_W-1:0]         n_rem;
    logic                              w_ge;

    // The first step compares the numerator as it is; every later step
    // shifts in the next low dividend bit.
    always_comb begin
        if (r_step == '0) begin
            w_trial = r_rem;
        end else begin
            w_trial = {r_rem[isa_pkg::REM_W-2:0], r_low[isa_pkg::FRACTION_BITS-1]};
        end
        w_ge   = (w_trial >= {1'b0, r_den});
        w_diff = w_trial - {1'b0, r_den};
        n_rem  = w_ge ? w_diff : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == isa_pkg::STEP_W'(isa_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + isa_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_low  <= i_low;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[isa_pkg::SIM_W-2:0], w_ge};
            if (r_step != '0) begin
                r_low <= {r_low[isa_pkg::FRACTION_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* rtl/isa_dp.sv */
// ----------------------------------------------------------------------------
// Similarity datapath
// Accumulators, Tanimoto denominator, shared divider and result register.
// ----------------------------------------------------------------------------
module isa_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  isa_pkg::t_dp_cmd          i_cmd,
    output isa_pkg::t_dp_stat         o_stat,
    input  logic [isa_pkg::PIX_W-1:0] i_pixel_first,
    input  logic [isa_pkg::PIX_W-1:0] i_pixel_second,
    isa_res_if.source                 o_res
);

    logic [isa_pkg::SQ_W-1:0]          r_inner;
    logic [isa_pkg::SQ_W-1:0]          r_sq_first;
    logic [isa_pkg::SQ_W-1:0]          r_sq_second;
    logic [isa_pkg::RATIO_W-1:0]       r_ratio;
    logic [isa_pkg::CNT_W-1:0]         r_count;
    logic                              r_ovf;
    logic                              r_ratio_en;
    logic [isa_pkg::DEN_W-1:0]         r_den;
    logic                              r_undef;
    logic [isa_pkg::SIM_W-1:0]         r_tan;
    logic                              r_out_valid;

    logic [isa_pkg::SIM_W-1:0]         r_o_tan;
    logic [isa_pkg::SIM_W-1:0]         r_o_mr;
    logic [isa_pkg::SQ_W-1:0]          r_o_inner;
    logic [isa_pkg::SQ_W-1:0]          r_o_sq_first;
    logic [isa_pkg::SQ_W-1:0]          r_o_sq_second;
    logic [isa_pkg::RATIO_W-1:0]       r_o_ratio;
    logic [isa_pkg::CNT_W-1:0]         r_o_count;
    logic                              r_o_undef;
    logic                              r_o_ovf;

    logic [isa_pkg::PIX_W-1:0]         w_lo;
    logic [isa_pkg::PIX_W-1:0]         w_hi;
    logic [isa_pkg::PROD_W-1:0]        w_ab;
    logic [isa_pkg::PROD_W-1:0]        w_aa;
    logic [isa_pkg::PROD_W-1:0]        w_bb;
    logic                              w_at_limit;
    logic                              w_both_nz;
    logic                              w_div_start;
    logic [isa_pkg::REM_W-1:0]         w_div_num;
    logic [isa_pkg::DEN_W-1:0]         w_div_den;
    logic [isa_pkg::FRACTION_BITS-1:0] w_div_low;
    logic                              w_div_busy;
    logic [isa_pkg::SIM_W-1:0]         w_quot;

    always_comb begin
        w_lo = (i_pixel_first < i_pixel_second) ? i_pixel_first : i_pixel_second;
        w_hi = (i_pixel_first < i_pixel_second) ? i_pixel_second : i_pixel_first;
        w_ab = isa_pkg::PROD_W'(i_pixel_first) * isa_pkg::PROD_W'(i_pixel_second);
        w_aa = isa_pkg::PROD_W'(i_pixel_first) * isa_pkg::PROD_W'(i_pixel_first);
        w_bb = isa_pkg::PROD_W'(i_pixel_second) * isa_pkg::PROD_W'(i_pixel_second);
        // The count never passes the limit, so its top bit marks a full image.
        w_at_limit = r_count[isa_pkg::CNT_W-1];
        w_both_nz  = (i_pixel_first != '0) && (i_pixel_second != '0);
    end

    always_comb begin
        w_div_start = (i_cmd.accept && !w_at_limit && w_both_nz)
                      || i_cmd.tan_start || i_cmd.mr_start;
        if (i_cmd.mr_start) begin
            // Mean ratio: the high part is at most the count, the low
            // fraction bits are brought down one per step.
            w_div_num = isa_pkg::REM_W'(r_ratio[isa_pkg::RATIO_W-1:isa_pkg::FRACTION_BITS]);
            w_div_den = isa_pkg::DEN_W'(r_count);
            w_div_low = r_ratio[isa_pkg::FRACTION_BITS-1:0];
        end else if (i_cmd.tan_start) begin
            w_div_num = isa_pkg::REM_W'(r_inner);
            w_div_den = r_den;
            w_div_low = '0;
        end else begin
            w_div_num = isa_pkg::REM_W'(w_lo);
            w_div_den = isa_pkg::DEN_W'(w_hi);
            w_div_low = '0;
        end
    end

    isa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_low   (w_div_low),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Accumulator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner     <= '0;
            r_sq_first  <= '0;
            r_sq_second <= '0;
            r_ratio     <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_ratio_en  <= 1'b0;
        end else if (i_cmd.finish) begin
            r_inner     <= '0;
            r_sq_first  <= '0;
            r_sq_second <= '0;
            r_ratio     <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_ratio_en  <= 1'b0;
        end else if (i_cmd.accept) begin
            if (w_at_limit) begin
                r_ovf      <= 1'b1;
                r_ratio_en <= 1'b0;
            end else begin
                r_inner     <= r_inner + isa_pkg::SQ_W'(w_ab);
                r_sq_first  <= r_sq_first + isa_pkg::SQ_W'(w_aa);
                r_sq_second <= r_sq_second + isa_pkg::SQ_W'(w_bb);
                r_count     <= r_count + isa_pkg::CNT_W'(1);
                r_ratio_en  <= w_both_nz;
            end
        end else if (i_cmd.ratio_add && r_ratio_en) begin
            r_ratio <= r_ratio + isa_pkg::RATIO_W'(w_quot);
        end
    end

    // Per-image working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.den_load) begin
            r_den <= isa_pkg::DEN_W'(r_sq_first) + isa_pkg::DEN_W'(r_sq_second)
                     - isa_pkg::DEN_W'(r_inner);
        end
        if (i_cmd.tan_start) begin
            r_undef <= (r_den == '0);
        end
        if (i_cmd.tan_save) begin
            r_tan <= w_quot;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_tan       <= r_undef ? '0 : r_tan;
            r_o_mr        <= w_quot;
            r_o_inner     <= r_inner;
            r_o_sq_first  <= r_sq_first;
            r_o_sq_second <= r_sq_second;
            r_o_ratio     <= r_ratio;
            r_o_count     <= r_count;
            r_o_undef     <= r_undef;
            r_o_ovf       <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_free = !r_out_valid || o_res.ready;

    assign o_res.valid                = r_out_valid;
    assign o_res.tanimoto_similarity  = r_o_tan;
    assign o_res.min_ratio_similarity = r_o_mr;
    assign o_res.inner_product        = r_o_inner;
    assign o_res.sum_squares_first    = r_o_sq_first;
    assign o_res.sum_squares_second   = r_o_sq_second;
    assign o_res.ratio_total          = r_o_ratio;
    assign o_res.pixel_total          = r_o_count;
    assign o_res.tanimoto_undefined   = r_o_undef;
    assign o_res.too_many_pixels      = r_o_ovf;

endmodule

/* rtl/isa_ctrl.sv */
// ----------------------------------------------------------------------------
// Similarity controller
// Sequences pixel accumulation and the two divisions at the end of an image.
// ----------------------------------------------------------------------------
module isa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_last,
    output logic               o_ready,
    output isa_pkg::t_dp_cmd   o_cmd,
    input  isa_pkg::t_dp_stat  i_stat
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_PIX_WAIT  = 3'd1;
    localparam logic [2:0] ST_TAN_PREP  = 3'd2;
    localparam logic [2:0] ST_TAN_START = 3'd3;
    localparam logic [2:0] ST_TAN_WAIT  = 3'd4;
    localparam logic [2:0] ST_MR_START  = 3'd5;
    localparam logic [2:0] ST_MR_WAIT   = 3'd6;
    localparam logic [2:0] ST_FINISH    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_last;
    logic       w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PIX_WAIT;
                end
            end
            ST_PIX_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.ratio_add = 1'b1;
                    n_state         = r_last ? ST_TAN_PREP : ST_IDLE;
                end
            end
            ST_TAN_PREP: begin
                o_cmd.den_load = 1'b1;
                n_state        = ST_TAN_START;
            end
            ST_TAN_START: begin
                o_cmd.tan_start = 1'b1;
                n_state         = ST_TAN_WAIT;
            end
            ST_TAN_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.tan_save = 1'b1;
                    n_state        = ST_MR_START;
                end
            end
            ST_MR_START: begin
                o_cmd.mr_start = 1'b1;
                n_state        = ST_MR_WAIT;
            end
            ST_MR_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_last <= i_last;
            end
        end
    end

endmodule

/* rtl/image_similarity_accumulator_top.sv */
// ----------------------------------------------------------------------------
// Image similarity accumulator
// Tanimoto and minimum-ratio similarity of two grayscale images.
// ----------------------------------------------------------------------------
// Pixel pairs of two equally sized 8-bit images enter one transaction at a
// time on i_pix; the pair flagged last_pixel closes the image. A pair with
// two nonzero pixels is accepted and its three products added, then the
// shared restoring divider forms the Q1.16 min/max ratio, one bit per cycle,
// and the ratio is added. A pair holding a zero pixel, or one beyond the
// limit of 2**22 pairs, skips the division: it is accepted, then a step
// follows that adds nothing to the ratio sum. After the last pair the same
// divider runs twice more, for the Tanimoto quotient and then for the mean
// ratio, before the result transaction appears on o_res. The result sits in
// its own output register, so new pixel pairs are taken while it waits; only
// a second image that finishes before the first result is taken has to wait
// for it.
// ----------------------------------------------------------------------------
module image_similarity_accumulator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isa_pix_if.sink   i_pix,
    isa_res_if.source o_res
);

    isa_pkg::t_dp_cmd  w_cmd;
    isa_pkg::t_dp_stat w_stat;
    logic              w_ready;

    // The controller owns the input handshake and sequences the datapath.
    isa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_last  (i_pix.last_pixel),
        .o_ready (w_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    assign i_pix.ready = w_ready;

    // The datapath holds the sums, the divider and the result register.
    isa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_pixel_first  (i_pix.pixel_first),
        .i_pixel_second (i_pix.pixel_second),
        .o_res          (o_res)
    );

    // A new pair is taken only while the divider is free.
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ready |-> !w_stat.div_busy)
        else $error("pixel pair accepted while the divider is busy");

    // A result is never loaded over one that has not been taken.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_stat.out_free)
        else $error("result register overwritten");

    // The controller issues at most one command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command");

    // An undefined Tanimoto value is reported as zero.
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.tanimoto_undefined) |-> (o_res.tanimoto_similarity == '0))
        else $error("undefined Tanimoto similarity is not zero");

endmodule
